// ===== rtl/set_assoc_lru_cache_controller_unit_defines.svh =====
// Assertion helpers for the cache controller. Both sample on the rising edge
// of clk and are disabled while rst is high.
`ifndef SET_ASSOC_LRU_CACHE_CONTROLLER_UNIT_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_CONTROLLER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SALC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SALC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/salc_pkg.sv =====
`default_nettype none
package salc_pkg;

  // Cache geometry.
  localparam int WAYS         = 4;
  localparam int SET_IDX_BITS = 6;
  localparam int OFFSET_BITS  = 6;
  localparam int TAG_WIDTH    = 20;

  localparam int ADDR_BITS = 32;
  localparam int AGE_BITS  = 32;
  localparam int LAT_BITS  = 16;

  localparam int NUM_SETS = 2 ** SET_IDX_BITS;
  localparam int SET_W    = (SET_IDX_BITS > 0) ? SET_IDX_BITS : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_LSB  = OFFSET_BITS + SET_IDX_BITS;
  localparam logic [ADDR_BITS-1:0] SET_MASK = ADDR_BITS'(NUM_SETS - 1);

  // Line states.
  localparam logic [1:0] LINE_FREE  = 2'd0;
  localparam logic [1:0] LINE_CLEAN = 2'd1;
  localparam logic [1:0] LINE_DIRTY = 2'd2;

  // Result kinds.
  localparam logic [2:0] KIND_FETCH_READ    = 3'd0;
  localparam logic [2:0] KIND_FETCH_WRITE   = 3'd1;
  localparam logic [2:0] KIND_WRITEBACK     = 3'd2;
  localparam logic [2:0] KIND_WRITE_THROUGH = 3'd3;
  localparam logic [2:0] KIND_DONE          = 3'd4;

  // Access commands.
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 16;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WRITE_THROUGH_MODE = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HIT_LATENCY        = 4'd1;

  typedef struct packed {
    logic [TAG_WIDTH-1:0] tag;
    logic [1:0]           line_state;
    logic [AGE_BITS-1:0]  age;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

endpackage
`default_nettype wire

// ===== rtl/salc_if.sv =====
`default_nettype none
// Access request channel.
interface salc_req_if;
  logic                              valid;
  logic                              ready;
  logic                              command;
  logic [salc_pkg::ADDR_BITS-1:0]    address;

  modport source (output valid, output command, output address, input ready);
  modport sink   (input valid, input command, input address, output ready);
endinterface

// Result channel toward the next level.
interface salc_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [2:0]                        kind;
  logic [salc_pkg::ADDR_BITS-1:0]    req_address;
  logic                              hit;
  logic [salc_pkg::LAT_BITS-1:0]     latency;
  logic                              last;

  modport source (output valid, output kind, output req_address, output hit,
                  output latency, output last, input ready);
  modport sink   (input valid, input kind, input req_address, input hit,
                  input latency, input last, output ready);
endinterface

// Configuration write channel.
interface salc_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [salc_pkg::CFG_INDEX_BITS-1:0]  index;
  logic [salc_pkg::CFG_DATA_BITS-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/set_assoc_lru_cache_controller_unit.sv =====
`default_nettype none
// Channel | Dir | Payload                                 | Transfer when
// req     | in  | command, address                        | req.valid && req.ready
// rsp     | out | kind, req_address, hit, latency, last   | rsp.valid && rsp.ready
// cfg     | in  | index, data                             | cfg.valid && cfg.ready
//
// An access goes through a lookup state on its set row, whose read is issued with the
// request transfer, then loads its result items (one to four) in turn into the output
// register. Loading the done item can take the next request in the same cycle.
// Reset is synchronous and clears the per-set valid bits at once, with no clearing pass.
// A stalled result holds only the item sequencer; the done item may wait in the output
// register while the next access runs.
`include "set_assoc_lru_cache_controller_unit_defines.svh"

module set_assoc_lru_cache_controller_unit (
  input wire logic      clk,
  input wire logic      rst,
  salc_req_if.sink      req,
  salc_rsp_if.source    rsp,
  salc_cfg_if.sink      cfg
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;

  // One memory row holds all ways of a set: tag, line state and age stamp.
  salc_pkg::row_t row_mem [salc_pkg::NUM_SETS];

  // A set that was never written reads as all ways free with zero age.
  logic [salc_pkg::NUM_SETS-1:0] row_valid;

  logic [1:0] state;

  // Configuration registers.
  logic                           wt_mode;
  logic [salc_pkg::LAT_BITS-1:0]  hit_lat;

  logic [salc_pkg::AGE_BITS-1:0]  access_clock;

  // The access under way.
  logic                            req_cmd;
  logic [salc_pkg::ADDR_BITS-1:0]  req_addr;
  salc_pkg::row_t                  rd_row;
  logic                            rd_valid;

  // Result items still owed by the current access, in emission order.
  logic                            pend_fetch;
  logic                            pend_wb;
  logic                            pend_wt;
  logic                            pend_done;
  logic                            acc_hit;
  logic [salc_pkg::ADDR_BITS-1:0]  wb_addr;

  // Output register.
  logic                            out_valid;
  logic [2:0]                      out_kind;
  logic [salc_pkg::ADDR_BITS-1:0]  out_addr;
  logic                            out_hit;
  logic [salc_pkg::LAT_BITS-1:0]   out_lat;
  logic                            out_last;

  logic in_acc;
  logic out_load;
  logic load_done;

  logic [salc_pkg::SET_W-1:0]      in_set;
  logic [salc_pkg::SET_W-1:0]      req_set;
  logic [salc_pkg::TAG_WIDTH-1:0]  req_tag;

  salc_pkg::row_t             cur_row;
  salc_pkg::row_t             new_row;
  logic [salc_pkg::WAYS-1:0]  match_vec;
  logic [salc_pkg::WAYS-1:0]  free_vec;
  logic [salc_pkg::WAYS-1:0]  oldest_vec;
  logic                       hit_any;
  logic                       free_any;
  logic [salc_pkg::WAY_W-1:0] hit_way;
  logic [salc_pkg::WAY_W-1:0] free_way;
  logic [salc_pkg::WAY_W-1:0] old_way;
  logic [salc_pkg::WAY_W-1:0] touch_way;
  logic                       need_wb;
  logic [63:0]                wb_wide;

  assign in_set  = salc_pkg::SET_W'((req.address >> salc_pkg::OFFSET_BITS) &
                                    salc_pkg::SET_MASK);
  assign req_set = salc_pkg::SET_W'((req_addr >> salc_pkg::OFFSET_BITS) &
                                    salc_pkg::SET_MASK);
  assign req_tag = salc_pkg::TAG_WIDTH'(req_addr >> salc_pkg::TAG_LSB);

  // The item sequencer loads the output register whenever it is empty or
  // its item leaves in this cycle. Loading the done item ends the access,
  // so a new request may be taken in that same cycle. Nothing is taken
  // while reset is held.
  assign out_load  = (state == ST_EMIT) && (!out_valid || rsp.ready);
  assign load_done = out_load && !pend_fetch && !pend_wb && !pend_wt;
  assign req.ready = !rst && ((state == ST_IDLE) || load_done);
  assign in_acc    = req.valid && req.ready;
  assign cfg.ready = !rst;

  // Lookup on the row read in the previous cycle.
  always_comb begin
    cur_row    = rd_row;
    match_vec  = '0;
    free_vec   = '0;
    oldest_vec = '0;
    hit_way    = '0;
    free_way   = '0;
    old_way    = '0;
    for (int w = 0; w < salc_pkg::WAYS; w++) begin
      if (!rd_valid) begin
        cur_row[w].line_state = salc_pkg::LINE_FREE;
        cur_row[w].age        = '0;
      end
    end
    for (int w = 0; w < salc_pkg::WAYS; w++) begin
      free_vec[w]  = (cur_row[w].line_state == salc_pkg::LINE_FREE);
      match_vec[w] = !free_vec[w] && (cur_row[w].tag == req_tag);
    end
    // A way is the oldest when it is strictly below every lower way and no
    // higher than every higher way, which breaks ties toward the lowest way.
    for (int w = 0; w < salc_pkg::WAYS; w++) begin
      oldest_vec[w] = 1'b1;
      for (int v = 0; v < salc_pkg::WAYS; v++) begin
        if (v < w && !(cur_row[w].age < cur_row[v].age)) begin
          oldest_vec[w] = 1'b0;
        end
        if (v > w && !(cur_row[w].age <= cur_row[v].age)) begin
          oldest_vec[w] = 1'b0;
        end
      end
    end
    // The lowest matching way, the highest free way.
    for (int w = salc_pkg::WAYS - 1; w >= 0; w--) begin
      if (match_vec[w]) begin
        hit_way = salc_pkg::WAY_W'(w);
      end
    end
    for (int w = 0; w < salc_pkg::WAYS; w++) begin
      if (free_vec[w]) begin
        free_way = salc_pkg::WAY_W'(w);
      end
      if (oldest_vec[w]) begin
        old_way = salc_pkg::WAY_W'(w);
      end
    end
  end

  assign hit_any   = |match_vec;
  assign free_any  = |free_vec;
  assign touch_way = hit_any ? hit_way : (free_any ? free_way : old_way);
  assign need_wb   = !hit_any && !free_any &&
                     (cur_row[old_way].line_state == salc_pkg::LINE_DIRTY);
  assign wb_wide   = (64'(cur_row[old_way].tag) << salc_pkg::TAG_LSB) |
                     (64'(req_set) << salc_pkg::OFFSET_BITS);

  // Updated row: the touched way takes the new stamp; a miss installs the tag.
  always_comb begin
    new_row = cur_row;
    new_row[touch_way].age = access_clock;
    if (hit_any) begin
      if (req_cmd == salc_pkg::CMD_WRITE && !wt_mode) begin
        new_row[touch_way].line_state = salc_pkg::LINE_DIRTY;
      end
    end else begin
      new_row[touch_way].tag = req_tag;
      if (req_cmd == salc_pkg::CMD_WRITE && !wt_mode) begin
        new_row[touch_way].line_state = salc_pkg::LINE_DIRTY;
      end else begin
        new_row[touch_way].line_state = salc_pkg::LINE_CLEAN;
      end
    end
  end

  // Set memory: the read is issued with the request transfer, the write-back
  // happens at the end of the lookup cycle, before any later read is issued.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_row   <= row_mem[in_set];
      rd_valid <= row_valid[in_set];
    end
    if (state == ST_LOOKUP) begin
      row_mem[req_set] <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      row_valid    <= '0;
      wt_mode      <= 1'b0;
      hit_lat      <= salc_pkg::LAT_BITS'(1);
      access_clock <= '0;
      pend_fetch   <= 1'b0;
      pend_wb      <= 1'b0;
      pend_wt      <= 1'b0;
      pend_done    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          salc_pkg::CFG_WRITE_THROUGH_MODE: wt_mode <= cfg.data[0];
          salc_pkg::CFG_HIT_LATENCY:        hit_lat <= cfg.data;
          default: ;
        endcase
      end

      if (in_acc) begin
        access_clock <= access_clock + salc_pkg::AGE_BITS'(1);
        req_cmd      <= req.command;
        req_addr     <= req.address;
      end

      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            state <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          row_valid[req_set] <= 1'b1;
          acc_hit    <= hit_any;
          wb_addr    <= wb_wide[salc_pkg::ADDR_BITS-1:0];
          pend_fetch <= !hit_any;
          pend_wb    <= need_wb;
          pend_wt    <= (req_cmd == salc_pkg::CMD_WRITE) && wt_mode;
          pend_done  <= 1'b1;
          state      <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_load) begin
            if (pend_fetch) begin
              pend_fetch <= 1'b0;
            end else if (pend_wb) begin
              pend_wb <= 1'b0;
            end else if (pend_wt) begin
              pend_wt <= 1'b0;
            end else begin
              pend_done <= 1'b0;
              state     <= in_acc ? ST_LOOKUP : ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // Output register: load the next owed item, in emission order.
      if (out_load) begin
        out_valid <= 1'b1;
        if (pend_fetch) begin
          out_kind <= (req_cmd == salc_pkg::CMD_WRITE) ? salc_pkg::KIND_FETCH_WRITE
                                                       : salc_pkg::KIND_FETCH_READ;
          out_addr <= req_addr;
          out_hit  <= 1'b0;
          out_lat  <= '0;
          out_last <= 1'b0;
        end else if (pend_wb) begin
          out_kind <= salc_pkg::KIND_WRITEBACK;
          out_addr <= wb_addr;
          out_hit  <= 1'b0;
          out_lat  <= '0;
          out_last <= 1'b0;
        end else if (pend_wt) begin
          out_kind <= salc_pkg::KIND_WRITE_THROUGH;
          out_addr <= req_addr;
          out_hit  <= 1'b0;
          out_lat  <= '0;
          out_last <= 1'b0;
        end else begin
          out_kind <= salc_pkg::KIND_DONE;
          out_addr <= req_addr;
          out_hit  <= acc_hit;
          out_lat  <= hit_lat;
          out_last <= 1'b1;
        end
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.kind        = out_kind;
  assign rsp.req_address = out_addr;
  assign rsp.hit         = out_hit;
  assign rsp.latency     = out_lat;
  assign rsp.last        = out_last;

  // A request transfer always leads straight into the lookup cycle.
  `SALC_ASSERT_NEXT(a_accept_to_lookup, in_acc, state == ST_LOOKUP, "request lost")
  // A tag is installed only on a miss, so no set holds it twice.
  `SALC_ASSERT_SAME(a_single_match, state == ST_LOOKUP, $countones(match_vec) <= 1,
                    "tag found in more than one way")
  // The sequencer never leaves an access before its done item is loaded.
  `SALC_ASSERT_SAME(a_done_owed, state == ST_EMIT, pend_done, "done item missing")

endmodule
`default_nettype wire

// ===== sim/set_assoc_lru_cache_controller_unit_tb.sv =====
`timescale 1ns / 100ps

module set_assoc_lru_cache_controller_unit_tb;

  localparam int NUM_LINES = salc_pkg::NUM_SETS * salc_pkg::WAYS;

  // One request that the controller is expected to send toward the next level.
  typedef struct {
    logic [2:0]                     kind;
    logic [salc_pkg::ADDR_BITS-1:0] req_address;
    logic                           hit;
    logic [salc_pkg::LAT_BITS-1:0]  latency;
    logic                           last;
  } cache_request_t;

  // Shadow copy of the tag, state and age arrays. Every accepted access is
  // played against it to produce the requests the controller must send, and
  // those requests wait in order until the result channel delivers them.
  class lru_tag_tracker;
    logic [salc_pkg::TAG_WIDTH-1:0] line_tag [NUM_LINES];
    logic [1:0]                     line_st [NUM_LINES];
    logic [salc_pkg::AGE_BITS-1:0]  line_age [NUM_LINES];
    logic [salc_pkg::AGE_BITS-1:0]  access_clock;
    logic                           write_through;
    logic [salc_pkg::LAT_BITS-1:0]  hit_cycles;
    cache_request_t                 pending_requests[$];
    int                             mismatch_count;
    int                             accesses;
    int                             hits;
    int                             writebacks;
    int                             write_throughs;
    int                             results_seen;

    function new();
      foreach (line_tag[i]) begin
        line_tag[i] = '0;
        line_st[i]  = salc_pkg::LINE_FREE;
        line_age[i] = '0;
      end
      access_clock   = '0;
      write_through  = 1'b0;
      hit_cycles     = 16'd1;
      mismatch_count = 0;
      accesses       = 0;
      hits           = 0;
      writebacks     = 0;
      write_throughs = 0;
      results_seen   = 0;
    endfunction

    function void write_register(logic [salc_pkg::CFG_INDEX_BITS-1:0] index,
                                 logic [salc_pkg::CFG_DATA_BITS-1:0] data);
      case (index)
        salc_pkg::CFG_WRITE_THROUGH_MODE: begin
          write_through = data[0];
        end
        salc_pkg::CFG_HIT_LATENCY: begin
          hit_cycles = data[salc_pkg::LAT_BITS-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void push_request(logic [2:0] kind,
                               logic [salc_pkg::ADDR_BITS-1:0] address,
                               logic hit, logic [salc_pkg::LAT_BITS-1:0] latency,
                               logic last);
      cache_request_t r;
      r.kind        = kind;
      r.req_address = address;
      r.hit         = hit;
      r.latency     = latency;
      r.last        = last;
      pending_requests.push_back(r);
    endfunction

    function void note_access(logic command, logic [salc_pkg::ADDR_BITS-1:0] address);
      logic [salc_pkg::SET_IDX_BITS-1:0] set_idx;
      logic [salc_pkg::TAG_WIDTH-1:0]    tag;
      int                                base;
      int                                victim;
      int                                i;
      set_idx = address[salc_pkg::OFFSET_BITS +: salc_pkg::SET_IDX_BITS];
      tag     = address[salc_pkg::TAG_LSB +: salc_pkg::TAG_WIDTH];
      base    = int'(set_idx) * salc_pkg::WAYS;
      victim  = -1;
      access_clock = access_clock + 1'b1;
      accesses++;

      for (int w = 0; w < salc_pkg::WAYS; w++) begin
        i = base + w;
        if (line_st[i] != salc_pkg::LINE_FREE && line_tag[i] == tag) begin
          line_age[i] = access_clock;
          if (command == salc_pkg::CMD_WRITE) begin
            if (write_through) begin
              push_request(salc_pkg::KIND_WRITE_THROUGH, address, 1'b0, '0, 1'b0);
              write_throughs++;
            end else begin
              line_st[i] = salc_pkg::LINE_DIRTY;
            end
          end
          push_request(salc_pkg::KIND_DONE, address, 1'b1, hit_cycles, 1'b1);
          hits++;
          return;
        end
      end

      push_request((command == salc_pkg::CMD_WRITE) ? salc_pkg::KIND_FETCH_WRITE
                                                    : salc_pkg::KIND_FETCH_READ,
                   address, 1'b0, '0, 1'b0);

      // The highest free way wins; with no free way the oldest stamp is
      // evicted, the lowest way taking ties.
      for (int w = 0; w < salc_pkg::WAYS; w++)
        if (line_st[base + w] == salc_pkg::LINE_FREE) victim = w;
      if (victim < 0) begin
        victim = 0;
        for (int w = 1; w < salc_pkg::WAYS; w++)
          if (line_age[base + w] < line_age[base + victim]) victim = w;
        if (line_st[base + victim] == salc_pkg::LINE_DIRTY) begin
          push_request(salc_pkg::KIND_WRITEBACK,
                       {line_tag[base + victim], set_idx,
                        {salc_pkg::OFFSET_BITS{1'b0}}},
                       1'b0, '0, 1'b0);
          writebacks++;
        end
      end

      i = base + victim;
      line_tag[i] = tag;
      line_age[i] = access_clock;
      line_st[i]  = (command == salc_pkg::CMD_WRITE && !write_through)
                    ? salc_pkg::LINE_DIRTY : salc_pkg::LINE_CLEAN;
      if (command == salc_pkg::CMD_WRITE && write_through) begin
        push_request(salc_pkg::KIND_WRITE_THROUGH, address, 1'b0, '0, 1'b0);
        write_throughs++;
      end
      push_request(salc_pkg::KIND_DONE, address, 1'b0, hit_cycles, 1'b1);
    endfunction

    task report_mismatch(string msg);
      mismatch_count++;
      $display("MISMATCH at time %0t: %s", $time, msg);
    endtask

    task check_result(logic [2:0] kind, logic [salc_pkg::ADDR_BITS-1:0] address,
                      logic hit, logic [salc_pkg::LAT_BITS-1:0] latency, logic last);
      cache_request_t exp_r;
      results_seen++;
      if (pending_requests.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d address %h", kind, address));
        return;
      end
      exp_r = pending_requests.pop_front();
      if (kind !== exp_r.kind)
        report_mismatch($sformatf("kind %0d, expected %0d (address %h)",
                                  kind, exp_r.kind, exp_r.req_address));
      if (address !== exp_r.req_address)
        report_mismatch($sformatf("req_address %h, expected %h (kind %0d)",
                                  address, exp_r.req_address, exp_r.kind));
      if (hit !== exp_r.hit)
        report_mismatch($sformatf("hit %b, expected %b (address %h)",
                                  hit, exp_r.hit, exp_r.req_address));
      if (latency !== exp_r.latency)
        report_mismatch($sformatf("latency %0d, expected %0d (address %h)",
                                  latency, exp_r.latency, exp_r.req_address));
      if (last !== exp_r.last)
        report_mismatch($sformatf("last %b, expected %b (address %h)",
                                  last, exp_r.last, exp_r.req_address));
    endtask

    task flush_leftovers();
      cache_request_t exp_r;
      while (pending_requests.size() != 0) begin
        exp_r = pending_requests.pop_front();
        report_mismatch($sformatf("missing result kind %0d address %h",
                                  exp_r.kind, exp_r.req_address));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  salc_req_if req_ch ();
  salc_rsp_if rsp_ch ();
  salc_cfg_if cfg_ch ();

  set_assoc_lru_cache_controller_unit i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always #10 clk = ~clk;

  lru_tag_tracker cache_model;

  // While a burst flag is set that side never idles, so back-to-back
  // transfers happen as well as gaps that land on every phase of an access.
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;

  logic [salc_pkg::TAG_WIDTH-1:0]    tag_pool [6];
  logic [salc_pkg::SET_IDX_BITS-1:0] set_pool [4];

  function automatic logic [salc_pkg::ADDR_BITS-1:0] make_addr(
      logic [salc_pkg::TAG_WIDTH-1:0] tag,
      logic [salc_pkg::SET_IDX_BITS-1:0] set_idx,
      logic [salc_pkg::OFFSET_BITS-1:0] offset);
    return {tag, set_idx, offset};
  endfunction

  // Offers one access on the request channel. The valid line is only lowered
  // when a gap is drawn, so an unbroken stream keeps it high across transfers.
  task automatic send_access(logic command, logic [salc_pkg::ADDR_BITS-1:0] address);
    int gap;
    if ($urandom_range(0, 24) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 18);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.command <= command;
    req_ch.address <= address;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    cache_model.note_access(command, address);
  endtask

  task automatic release_requests();
    @(negedge clk);
    req_ch.valid <= 1'b0;
  endtask

  // Waits until every predicted request has been seen, then lets the clock
  // run on so that the controller is idle before its registers change.
  task automatic wait_drained();
    while (cache_model.pending_requests.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg_reg(logic [salc_pkg::CFG_INDEX_BITS-1:0] index,
                               logic [salc_pkg::CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cache_model.write_register(index, data);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random accesses aimed mostly at a few sets and a few tags so that the
  // sets fill up, lines hit, and dirty victims get written back. The rest
  // spread over the whole address space.
  task automatic run_random_phase(int count);
    logic [salc_pkg::SET_IDX_BITS-1:0] set_idx;
    logic [salc_pkg::TAG_WIDTH-1:0]    tag;
    foreach (tag_pool[k]) tag_pool[k] = salc_pkg::TAG_WIDTH'($urandom);
    foreach (set_pool[k]) set_pool[k] = salc_pkg::SET_IDX_BITS'($urandom);
    for (int n = 0; n < count; n++) begin
      set_idx = ($urandom_range(0, 9) < 7) ? set_pool[$urandom_range(0, 3)]
                                           : salc_pkg::SET_IDX_BITS'($urandom);
      tag     = ($urandom_range(0, 9) < 7) ? tag_pool[$urandom_range(0, 5)]
                                           : salc_pkg::TAG_WIDTH'($urandom);
      send_access(1'($urandom),
                  make_addr(tag, set_idx, salc_pkg::OFFSET_BITS'($urandom)));
      // Now and then the sender holds off until every result is back.
      if ($urandom_range(0, 39) == 0) begin
        release_requests();
        wait_drained();
      end
    end
  endtask

  // Result side: unless a burst is running, ready drops for a random stall before
  // each transfer, and every transfer is checked against the oldest prediction.
  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if ($urandom_range(0, 24) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 18);
      @(negedge clk);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      cache_model.check_result(rsp_ch.kind, rsp_ch.req_address, rsp_ch.hit,
                               rsp_ch.latency, rsp_ch.last);
    end
  end

  // This bound sits several times above the slowest legal run.
  initial begin
    #5000000;
    $display("Timeout: the run did not finish in time.");
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [salc_pkg::CFG_DATA_BITS-1:0] phase_mode [4];
    logic [salc_pkg::CFG_DATA_BITS-1:0] phase_lat [4];
    int                                 spare;

    req_ch.valid   = 1'b0;
    req_ch.command = salc_pkg::CMD_READ;
    req_ch.address = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = salc_pkg::CFG_WRITE_THROUGH_MODE;
    cfg_ch.data    = '0;
    cache_model    = new();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings (write-back, reset hit latency). All
    // of it works on one set: a miss into free ways, hits, a write hit that
    // dirties a line, a full set, and an eviction of a dirty oldest line.
    send_access(salc_pkg::CMD_READ,  make_addr(20'h00001, 6'd5, 6'd0));
    send_access(salc_pkg::CMD_READ,  make_addr(20'h00001, 6'd5, 6'd63));
    send_access(salc_pkg::CMD_WRITE, make_addr(20'hA5A5A, 6'd5, 6'd1));
    send_access(salc_pkg::CMD_WRITE, make_addr(20'h00001, 6'd5, 6'd2));
    send_access(salc_pkg::CMD_READ,  make_addr(20'h5A5A5, 6'd5, 6'd3));
    send_access(salc_pkg::CMD_READ,  make_addr(20'hFFFFE, 6'd5, 6'd4));
    send_access(salc_pkg::CMD_READ,  make_addr(20'h12345, 6'd5, 6'd5));
    send_access(salc_pkg::CMD_WRITE, make_addr(20'h5A5A5, 6'd5, 6'd6));
    // Address extremes, which also land in the first and last sets.
    send_access(salc_pkg::CMD_READ,  32'h0000_0000);
    send_access(salc_pkg::CMD_WRITE, 32'hFFFF_FFFF);
    send_access(salc_pkg::CMD_READ,  32'hFFFF_FFFF);
    send_access(salc_pkg::CMD_WRITE, 32'h0000_0000);
    release_requests();
    wait_drained();

    // Write-through with the largest latency. The mode value carries upper
    // bits that must be dropped, and a write to an unknown index must leave
    // both registers alone.
    write_cfg_reg(salc_pkg::CFG_WRITE_THROUGH_MODE, 16'hFFFF);
    write_cfg_reg(salc_pkg::CFG_HIT_LATENCY, 16'hFFFF);
    write_cfg_reg(salc_pkg::CFG_INDEX_BITS'(15), 16'h5A5A);

    // Write hits, write misses and reads in write-through mode. The set still holds
    // dirty lines, so two of the write misses bring a fetch, a writeback and a
    // write-through before the final done transfer.
    send_access(salc_pkg::CMD_WRITE, make_addr(20'h12345, 6'd5, 6'd7));
    send_access(salc_pkg::CMD_WRITE, make_addr(20'h0F0F0, 6'd5, 6'd8));
    send_access(salc_pkg::CMD_WRITE, make_addr(20'hF0F0F, 6'd5, 6'd9));
    send_access(salc_pkg::CMD_WRITE, make_addr(20'h33333, 6'd5, 6'd10));
    send_access(salc_pkg::CMD_READ,  make_addr(20'h0F0F0, 6'd5, 6'd11));
    send_access(salc_pkg::CMD_READ,  make_addr(20'hCCCCC, 6'd7, 6'd0));
    send_access(salc_pkg::CMD_WRITE, make_addr(20'hCCCCC, 6'd7, 6'd1));

    // Random phases, each under its own setting of both registers.
    phase_mode[0] = 16'h0000;
    phase_lat[0]  = 16'h0000;
    phase_mode[1] = 16'h0001;
    phase_lat[1]  = salc_pkg::CFG_DATA_BITS'($urandom);
    phase_mode[2] = 16'hFFFE;
    phase_lat[2]  = 16'hFFFF;
    phase_mode[3] = 16'h8001;
    phase_lat[3]  = salc_pkg::CFG_DATA_BITS'($urandom);
    for (int p = 0; p < 4; p++) begin
      release_requests();
      wait_drained();
      write_cfg_reg(salc_pkg::CFG_WRITE_THROUGH_MODE, phase_mode[p]);
      write_cfg_reg(salc_pkg::CFG_HIT_LATENCY, phase_lat[p]);
      if (p == 3)
        write_cfg_reg(salc_pkg::CFG_INDEX_BITS'($urandom_range(2, 15)),
                      salc_pkg::CFG_DATA_BITS'($urandom));
      run_random_phase(65);
    end
    release_requests();

    // Let the last results come back, within a bound, then keep the clock
    // running to catch anything sent beyond the prediction.
    spare = 0;
    while (cache_model.pending_requests.size() != 0 && spare < 5000) begin
      @(posedge clk);
      spare++;
    end
    cache_model.flush_leftovers();
    repeat (20) @(posedge clk);

    $display("Covered %0d accesses: %0d hits, %0d misses, %0d result transfers checked.",
             cache_model.accesses, cache_model.hits,
             cache_model.accesses - cache_model.hits, cache_model.results_seen);
    $display("Dirty writebacks %0d, write-throughs %0d, under both policies and latencies %s",
             cache_model.writebacks, cache_model.write_throughs, "from 0 to 65535.");
    if (cache_model.mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
